// ===== src/deq_pkg.sv =====
package deq_pkg;

   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int CMD_W      = 3;
   localparam int VAL_W      = 32;
   localparam int OCC_W      = 11;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      word_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] front_value;
      logic signed [VAL_W-1:0] back_value;
      logic                    is_empty;
      logic                    push_dropped;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

   // base + off modulo DEPTH, with base < DEPTH and off <= DEPTH
   function automatic idx_type idx_add(idx_type base, cnt_type off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return IDX_W'(sum);
   endfunction

   function automatic idx_type idx_dec(idx_type base);
      idx_type r;
      if (base == '0) begin
         r = IDX_W'(DEPTH - 1);
      end else begin
         r = base - IDX_W'(1);
      end
      return r;
   endfunction

   function automatic idx_type idx_inc(idx_type base);
      idx_type r;
      if (base == IDX_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = base + IDX_W'(1);
      end
      return r;
   endfunction

   // sign-extend a stored word to the 32-bit result field
   function automatic logic signed [VAL_W-1:0] widen(word_type w);
      logic signed [63:0] t;
      t = 64'($signed(w));
      return t[VAL_W-1:0];
   endfunction

   function automatic word_type narrow(logic signed [VAL_W-1:0] v);
      logic [63:0] t;
      t = 64'($unsigned(v));
      return t[DATA_WIDTH-1:0];
   endfunction

endpackage

// ===== src/deq_ram.sv =====
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/deq_ctrl.sv =====
module deq_ctrl import deq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_command,
   input  logic signed [VAL_W-1:0] req_value,
   output ram_req_type             ram_req,
   input  word_type                rd_data,
   output logic                    res_valid,
   output rsp_type                 res,
   input  logic                    res_ready
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LOAD = 1'b1;

   logic     state_ff, state_in;
   idx_type  head_ff, head_in;
   cnt_type  count_ff, count_in;
   word_type front_ff, front_in;
   word_type back_ff, back_in;
   logic     rd_front_ff, rd_front_in;
   logic     rd_back_ff, rd_back_in;
   logic     dropped_ff, dropped_in;

   logic     accept, done, full, empty;
   word_type word, front_new, back_new;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign done      = (state_ff == S_LOAD) && res_ready;
   assign word      = narrow(req_value);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   // a read issued at accept overrides the cached end
   assign front_new = rd_front_ff ? rd_data : front_ff;
   assign back_new  = rd_back_ff ? rd_data : back_ff;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      rd_front_in = rd_front_ff;
      rd_back_in  = rd_back_ff;
      dropped_in  = dropped_ff;
      ram_req         = '0;
      ram_req.wr_data = word;
      if (accept) begin
         state_in    = S_LOAD;
         rd_front_in = 1'b0;
         rd_back_in  = 1'b0;
         dropped_in  = 1'b0;
         case (req_command)
            CMD_PUSH_FRONT: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  head_in         = idx_dec(head_ff);
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = head_in;
                  front_in        = word;
                  if (empty) begin
                     back_in = word;
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = idx_add(head_ff, count_ff);
                  back_in         = word;
                  if (empty) begin
                     front_in = word;
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP_FRONT: begin
               if (!empty) begin
                  head_in  = idx_inc(head_ff);
                  count_in = count_ff - CNT_W'(1);
                  if (count_ff > CNT_W'(2)) begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = head_in;
                     rd_front_in     = 1'b1;
                  end else begin
                     front_in = back_ff;
                  end
               end
            end
            CMD_POP_BACK: begin
               if (!empty) begin
                  count_in = count_ff - CNT_W'(1);
                  if (count_ff > CNT_W'(2)) begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = idx_add(head_ff, count_ff - CNT_W'(2));
                     rd_back_in      = 1'b1;
                  end else begin
                     back_in = front_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (done) begin
         state_in    = S_IDLE;
         front_in    = front_new;
         back_in     = back_new;
         rd_front_in = 1'b0;
         rd_back_in  = 1'b0;
      end
   end

   always_comb begin
      res_valid        = (state_ff == S_LOAD);
      res.is_empty     = empty;
      res.push_dropped = dropped_ff;
      res.occupancy    = OCC_W'(count_ff);
      res.front_value  = empty ? '0 : widen(front_new);
      res.back_value   = empty ? '0 : widen(back_new);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         rd_front_ff <= 1'b0;
         rd_back_ff  <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         rd_front_ff <= rd_front_in;
         rd_back_ff  <= rd_back_in;
         dropped_ff  <= dropped_in;
      end
      front_ff <= front_in;
      back_ff  <= back_in;
   end

endmodule

// ===== src/double_ended_queue_top.sv =====
// Double-ended queue of DATA_WIDTH-bit signed words (1024 entries) in a ring
// buffer held in one synchronous RAM with a registered read. Each request
// word carries a command (push front, push back, pop front, pop back, peek;
// unused codes act as peek) and a value; each one returns exactly one
// response word with the front and back elements after the command (zero
// when empty), an empty flag, a flag for a push refused on a full queue, and
// the element count. A pop on an empty queue changes nothing. The accept
// cycle updates the pointers and issues the RAM write or the one RAM read a
// pop may need; once the response register can take a word, the load state
// folds the read data into the cached front/back words and loads that
// register. No new request is taken until then. The response register lets
// a new request enter while the previous response still waits on rsp_ready.
// No clearing pass runs after reset; the queue is ready in the first cycle
// after reset drops.
module double_ended_queue_top import deq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_command,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_front_value,
   output logic signed [VAL_W-1:0] rsp_back_value,
   output logic                    rsp_is_empty,
   output logic                    rsp_push_dropped,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   ram_req_type ram_req;
   word_type    rd_data;
   logic        res_valid;
   logic        res_ready;
   rsp_type     res;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   // pointers, end caches and sequencing
   deq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_value   (req_value),
      .ram_req     (ram_req),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res         (res),
      .res_ready   (res_ready)
   );

   // element storage
   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   // response register: load when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      // hold the payload until a new word is loaded
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_front_value  = rsp_ff.front_value;
   assign rsp_back_value   = rsp_ff.back_value;
   assign rsp_is_empty     = rsp_ff.is_empty;
   assign rsp_push_dropped = rsp_ff.push_dropped;
   assign rsp_occupancy    = rsp_ff.occupancy;

endmodule

// ===== src/deq_checker.sv =====
module deq_checker import deq_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [VAL_W-1:0] rsp_front_value,
   input logic signed [VAL_W-1:0] rsp_back_value,
   input logic                    rsp_is_empty,
   input logic                    rsp_push_dropped,
   input logic [OCC_W-1:0]        rsp_occupancy
);

   // empty queue reports zero count and zero end words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |->
         rsp_occupancy == '0 && rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty response with nonzero fields");

   // a refused push only happens on a full queue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_dropped |->
         !rsp_is_empty && rsp_occupancy == OCC_W'(DEPTH))
      else $error("push dropped while queue not full");

   // a single element is both front and back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_occupancy == OCC_W'(1) && !rsp_is_empty |->
         rsp_front_value == rsp_back_value)
      else $error("single element with differing ends");

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_front_value) && $stable(rsp_back_value)
         && $stable(rsp_occupancy))
      else $error("response changed while stalled");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);

// ===== tb/deq_scoreboard_pkg.sv =====
package deq_scoreboard_pkg;
   import deq_pkg::*;

   class deque_scoreboard;
      word_type    ring [DEPTH];
      int unsigned head_slot;
      int unsigned held;
      rsp_type     expected_words [$];
      int          errors;

      function new();
         head_slot = 0;
         held      = 0;
         errors    = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // apply one accepted request to the mirror and queue its response word
      function void note_request(logic [CMD_W-1:0] command, logic signed [VAL_W-1:0] value);
         rsp_type     want;
         word_type    word;
         logic        refused;
         int unsigned tail_slot;
         word    = word_type'($unsigned(value));
         refused = 1'b0;
         case (command)
            CMD_PUSH_FRONT: begin
               if (held >= DEPTH) begin
                  refused = 1'b1;
               end else begin
                  head_slot       = (head_slot + DEPTH - 1) % DEPTH;
                  ring[head_slot] = word;
                  held++;
               end
            end
            CMD_PUSH_BACK: begin
               if (held >= DEPTH) begin
                  refused = 1'b1;
               end else begin
                  ring[(head_slot + held) % DEPTH] = word;
                  held++;
               end
            end
            CMD_POP_FRONT: begin
               if (held > 0) begin
                  head_slot = (head_slot + 1) % DEPTH;
                  held--;
               end
            end
            CMD_POP_BACK: begin
               if (held > 0) begin
                  held--;
               end
            end
            default: begin
            end
         endcase
         if (held == 0) begin
            want.front_value = '0;
            want.back_value  = '0;
            want.is_empty    = 1'b1;
         end else begin
            tail_slot        = (head_slot + held - 1) % DEPTH;
            want.front_value = VAL_W'($signed(ring[head_slot]));
            want.back_value  = VAL_W'($signed(ring[tail_slot]));
            want.is_empty    = 1'b0;
         end
         want.push_dropped = refused;
         want.occupancy    = OCC_W'(held);
         expected_words = {expected_words, want};
      endfunction

      // compare one response word with the oldest expectation
      function void check_response(rsp_type seen);
         rsp_type want;
         if (expected_words.size() == 0) begin
            $error("response word arrived with none expected");
            errors++;
            return;
         end
         want = expected_words[0];
         expected_words.delete(0);
         if (seen.front_value !== want.front_value) begin
            $error("front_value expected %0d, actual %0d", want.front_value, seen.front_value);
            errors++;
         end
         if (seen.back_value !== want.back_value) begin
            $error("back_value expected %0d, actual %0d", want.back_value, seen.back_value);
            errors++;
         end
         if (seen.is_empty !== want.is_empty) begin
            $error("is_empty expected %0d, actual %0d", want.is_empty, seen.is_empty);
            errors++;
         end
         if (seen.push_dropped !== want.push_dropped) begin
            $error("push_dropped expected %0d, actual %0d",
                   want.push_dropped, seen.push_dropped);
            errors++;
         end
         if (seen.occupancy !== want.occupancy) begin
            $error("occupancy expected %0d, actual %0d", want.occupancy, seen.occupancy);
            errors++;
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_double_ended_queue_top.sv =====
module tb_double_ended_queue_top;
   import deq_pkg::*;
   import deq_scoreboard_pkg::*;

   // command codes with no operation of their own; the block treats them as peek
   localparam logic [CMD_W-1:0] CMD_SPARE_0 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_1 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_2 = 3'd7;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [CMD_W-1:0]        req_command;
   logic signed [VAL_W-1:0] req_value;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_front_value;
   logic signed [VAL_W-1:0] rsp_back_value;
   logic                    rsp_is_empty;
   logic                    rsp_push_dropped;
   logic [OCC_W-1:0]        rsp_occupancy;

   deque_scoreboard sb = new();

   // idle rates in percent per word; quiet turns off all idling for the tail of the run
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   bit          quiet         = 1'b0;

   rsp_type seen_word;

   double_ended_queue_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_push_dropped (rsp_push_dropped),
      .rsp_occupancy    (rsp_occupancy)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hold one request word on the port until the block takes it, then note it
   // in the scoreboard. Valid is only raised here and only lowered by the idle
   // helpers, so no time step sees two assignments to it.
   task automatic send_word(logic [CMD_W-1:0] command, logic signed [VAL_W-1:0] value);
      req_valid   <= 1'b1;
      req_command <= command;
      req_value   <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(command, value);
   endtask

   // Drop valid for a random burst now and then, then send the word.
   task automatic send_with_gaps(logic [CMD_W-1:0] command,
                                 logic signed [VAL_W-1:0] value);
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      send_word(command, value);
   endtask

   // Extremes show up often so sign handling gets hit on both ends.
   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = VAL_MIN;
         1:       v = VAL_MAX;
         2:       v = '0;
         3:       v = '1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Push share sets whether the queue tends to grow or shrink over a phase.
   function automatic logic [CMD_W-1:0] pick_command(int unsigned push_pct);
      int unsigned r;
      logic [CMD_W-1:0] c;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         c = CMD_W'($urandom_range(CMD_PEEK, CMD_SPARE_2));
      end else if (r < 10 + push_pct * 90 / 100) begin
         c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else begin
         c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end
      return c;
   endfunction

   task automatic run_mix(int unsigned words, int unsigned push_pct);
      repeat (words) send_with_gaps(pick_command(push_pct), pick_value());
   endtask

   // Stop sending until the block has answered every word in flight.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Result channel: stall in random bursts, with stretches of none.
   initial begin
      rsp_ready <= 1'b0;
      repeat (10) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Check each response word taken by the handshake.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word.front_value  = rsp_front_value;
         seen_word.back_value   = rsp_back_value;
         seen_word.is_empty     = rsp_is_empty;
         seen_word.push_dropped = rsp_push_dropped;
         seen_word.occupancy    = rsp_occupancy;
         sb.check_response(seen_word);
      end
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_command <= CMD_PEEK;
      req_value   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: look at and pop an empty queue, including the spare codes.
      send_word(CMD_PEEK, '0);
      send_word(CMD_POP_FRONT, VAL_MAX);
      send_word(CMD_POP_BACK, VAL_MIN);
      send_word(CMD_SPARE_0, '1);
      send_word(CMD_SPARE_1, '0);
      send_word(CMD_SPARE_2, VAL_MAX);
      // Push at both ends; the first front push wraps the head below slot zero.
      send_word(CMD_PUSH_FRONT, VAL_MIN);
      send_word(CMD_PUSH_BACK, VAL_MAX);
      send_word(CMD_PEEK, '0);
      send_word(CMD_PUSH_FRONT, '1);
      send_word(CMD_PUSH_BACK, '0);
      send_word(CMD_SPARE_0, VAL_MIN);
      send_word(CMD_SPARE_1, VAL_MAX);
      send_word(CMD_SPARE_2, '1);
      send_word(CMD_POP_BACK, '1);
      send_word(CMD_POP_FRONT, '0);
      send_word(CMD_POP_FRONT, '0);
      send_word(CMD_PUSH_BACK, 32'sd1);
      send_word(CMD_POP_BACK, '0);
      // Back to empty, then one more pop on the empty queue.
      send_word(CMD_POP_FRONT, '0);
      send_word(CMD_POP_BACK, '0);
      send_word(CMD_PUSH_FRONT, 32'sd2);
      send_word(CMD_PEEK, '0);

      // Random phases: vary the push share and the idle rates; some phases
      // run with no idling at all on either side, and the last one runs
      // with none for the tail of the run.
      for (int phase = 0; phase < 8; phase++) begin
         send_idle_pct = (phase == 2 || phase == 5) ? 0 : 25;
         stall_pct     = (phase == 2 || phase == 5) ? 0 : 25;
         if (phase == 7) begin
            quiet = 1'b1;
         end
         case (phase)
            0:       run_mix(100, 60);
            1:       run_mix(100, 50);
            2:       run_mix(100, 80);
            3:       run_mix(100, 20);
            4:       run_mix(100, 55);
            5:       run_mix(100, 45);
            6:       run_mix(100, 95);
            default: run_mix(100, 5);
         endcase
         if (phase == 3) begin
            drain_responses();
         end
      end

      // Tail of the run: drain to empty at full rate, then pop once more.
      while (sb.held > 0) begin
         send_word($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, pick_value());
      end
      send_word(CMD_POP_FRONT, '0);
      send_word(CMD_PEEK, '0);

      // Wait out every response, then a few cycles for anything stray.
      drain_responses();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/double_ended_queue_top.sv
src/deq_checker.sv
tb/deq_scoreboard_pkg.sv
tb/tb_double_ended_queue_top.sv
